FILE: design/sfpl_pkg.sv
// ----------------------------------------------------------------------------
// sfpl_pkg
// Shared types, frame constants and digit decode for the scale frame parser.
// ----------------------------------------------------------------------------
package sfpl_pkg;

    localparam logic [7:0] FRAME_HEAD   = 8'h81;
    localparam logic [7:0] FRAME_SECOND = 8'h00;
    localparam logic [7:0] FRAME_TAIL   = 8'hAA;

    localparam int WEIGHT_W   = 7;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Classified item passed from front to back
    typedef struct packed {
        logic                seen;
        logic [WEIGHT_W-1:0] whole;
        logic [WEIGHT_W-1:0] frac;
    } sfpl_item_t;

    // BCD digits read most significant first, stopping at the first nibble above 9
    function automatic logic [WEIGHT_W-1:0] decode_digits(input logic [7:0] b);
        logic [3:0]          hi;
        logic [3:0]          lo;
        logic [WEIGHT_W-1:0] hi_ext;
        logic [WEIGHT_W-1:0] lo_ext;
        hi     = b[7:4];
        lo     = b[3:0];
        hi_ext = {3'b000, hi};
        lo_ext = {3'b000, lo};
        if (hi == 4'd0) begin
            decode_digits = (lo <= 4'd9) ? lo_ext : '0;
        end else if (hi > 4'd9) begin
            decode_digits = '0;
        end else if (lo > 4'd9) begin
            decode_digits = hi_ext;
        end else begin
            decode_digits = (hi_ext << 3) + (hi_ext << 1) + lo_ext;
        end
    endfunction

endpackage

FILE: design/sfpl_front.sv
// ----------------------------------------------------------------------------
// sfpl_front
// Byte window, frame match and BCD decode; emits one classified item per byte.
// ----------------------------------------------------------------------------
module sfpl_front
    import sfpl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [S_DATA_W-1:0] in_byte,
    input  logic                q_full,
    output logic                in_ready,
    output logic                push,
    output sfpl_item_t          push_item
);

    logic [7:0] window_reg [4];
    logic [7:0] window_next [4];
    logic       match;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign match = (window_reg[0] == FRAME_HEAD) && (window_reg[1] == FRAME_SECOND) &&
                   (in_byte == FRAME_TAIL);

    always_comb begin
        push_item.seen  = match;
        push_item.whole = match ? decode_digits(window_reg[2]) : '0;
        push_item.frac  = match ? decode_digits(window_reg[3]) : '0;
    end

    always_comb begin
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = window_reg[3];
        window_next[3] = in_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                window_reg[i] <= '0;
            end
        end else if (push) begin
            window_reg <= window_next;
        end
    end

endmodule

FILE: design/sfpl_queue.sv
// ----------------------------------------------------------------------------
// sfpl_queue
// Two-entry queue decoupling the classifier from the lock tracker.
// ----------------------------------------------------------------------------
module sfpl_queue
    import sfpl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  sfpl_item_t push_item,
    input  logic       pop,
    output logic       full,
    output logic       avail,
    output sfpl_item_t pop_item
);

    sfpl_item_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign avail    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/sfpl_back.sv
// ----------------------------------------------------------------------------
// sfpl_back
// Lock tracker and output register.
// The ring of recent measurements is tracked as the run length of identical
// trailing writes; the ring is uniform once that run covers every slot.
// ----------------------------------------------------------------------------
module sfpl_back
    import sfpl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_avail,
    input  sfpl_item_t q_item,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output sfpl_item_t out_item,
    output logic       out_locked
);

    localparam int RUN_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(HISTORY_DEPTH);

    logic [RUN_W-1:0]    run_reg;
    logic [RUN_W-1:0]    run_next;
    logic [WEIGHT_W-1:0] last_whole_reg;
    logic [WEIGHT_W-1:0] last_frac_reg;
    logic                out_valid_reg;
    sfpl_item_t          out_item_reg;
    logic                out_locked_reg;
    logic                same;
    logic                locked_next;

    assign pop        = q_avail && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;
    assign out_locked = out_locked_reg;

    assign same = (q_item.whole == last_whole_reg) && (q_item.frac == last_frac_reg);

    always_comb begin
        run_next = run_reg;
        if (q_item.seen) begin
            if (!same) begin
                run_next = RUN_W'(1);
            end else if (run_reg != RUN_FULL) begin
                run_next = run_reg + 1'b1;
            end
        end
        locked_next = q_item.seen && (run_next == RUN_FULL) && (q_item.whole != '0);
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_item_reg   <= q_item;
            out_locked_reg <= locked_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            run_reg        <= RUN_FULL;
            last_whole_reg <= '0;
            last_frac_reg  <= '0;
        end else begin
            if (pop) begin
                out_valid_reg <= 1'b1;
                run_reg       <= run_next;
                if (q_item.seen) begin
                    last_whole_reg <= q_item.whole;
                    last_frac_reg  <= q_item.frac;
                end
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_lock_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_locked_reg |-> out_item_reg.seen && out_item_reg.whole != '0)
        else $error("lock flagged without a frame or with zero weight");
    a_run_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg != '0 && run_reg <= RUN_FULL)
        else $error("run length out of range");
    a_no_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_item_reg.seen |->
            out_item_reg.whole == '0 && out_item_reg.frac == '0 && !out_locked_reg)
        else $error("non-frame item carries data");
    a_new_value_resets_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && q_item.seen && !same |=> run_reg == RUN_W'(1))
        else $error("run not restarted on a new measurement");
`endif

endmodule

FILE: design/scale_frame_parse_and_lock.sv
// ----------------------------------------------------------------------------
// scale_frame_parse_and_lock
// Parses 81 00 W F AA frames from a scale byte stream and flags weight lock.
// Path: an accepted byte's result goes through the queue write, then the output
//   register, before it shows on m_tvalid.
// Throughput: one item per cycle; s_tready drops only when the two-entry
//   queue is full because the output register is held by m_tready low.
// Reset: aresetn (synchronous, active low) clears the byte window, the lock
//   run tracker (all slots taken as zero), the queue and the output valid.
// ----------------------------------------------------------------------------
module scale_frame_parse_and_lock
    import sfpl_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [6:0] weight_whole, [13:7] weight_hundredths,
                                           // [14] weight_locked, [15] zero
    output logic                m_tuser    // [0] frame_seen
);

    logic       push;
    sfpl_item_t push_item;
    logic       q_full;
    logic       q_avail;
    logic       pop;
    sfpl_item_t q_item;
    sfpl_item_t out_item;
    logic       out_locked;

    sfpl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    sfpl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .avail     (q_avail),
        .pop_item  (q_item)
    );

    sfpl_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_avail    (q_avail),
        .q_item     (q_item),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_item   (out_item),
        .out_locked (out_locked)
    );

    assign m_tdata = {1'b0, out_locked, out_item.frac, out_item.whole};
    assign m_tuser = out_item.seen;

endmodule
